FILE: src/amulp_pkg.sv
// Shared types, codes and keyword tables of the modem event-line parser.
`timescale 1ns / 1ps
`default_nettype none
package amulp_pkg;

  // Item function codes on the input channel (tuser)
  localparam logic [1:0] FUNC_BYTE    = 2'd0;
  localparam logic [1:0] FUNC_START   = 2'd1;
  localparam logic [1:0] FUNC_CONSUME = 2'd2;

  // Characters with a special role
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] CH_N    = 8'h4E;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_E    = 8'h45;
  localparam logic [7:0] CH_G    = 8'h47;
  localparam logic [7:0] CH_O    = 8'h4F;
  localparam logic [7:0] CH_K    = 8'h4B;
  localparam logic [7:0] CH_ONE  = 8'h31;

  // Class of an accepted beat, worked out by the front end
  typedef enum logic [2:0] {
    KIND_PLUS    = 3'd0,
    KIND_LF      = 3'd1,
    KIND_CR      = 3'd2,
    KIND_BYTE    = 3'd3,
    KIND_START   = 3'd4,
    KIND_CONSUME = 3'd5,
    KIND_NOP     = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } item_t;

  // Keyword tracker: single candidates 1..4, prefixes "+" and "+C"
  typedef enum logic [2:0] {
    KW_NONE   = 3'd0,
    KW_CSCON  = 3'd1,
    KW_CEREG  = 3'd2,
    KW_CGATT  = 3'd3,
    KW_NSONMI = 3'd4,
    KW_PLUS_C = 3'd6,
    KW_PLUS   = 3'd7
  } kw_t;

  typedef enum logic [1:0] {
    RESP_NONE  = 2'd0,
    RESP_OK    = 2'd1,
    RESP_ERROR = 2'd2
  } resp_t;

  localparam logic [3:0] STATUS_KW_LEN = 4'd7;
  localparam logic [3:0] NOTICE_KW_LEN = 4'd8;
  localparam logic [3:0] FLAG_POS      = 4'd7;
  localparam logic [3:0] POS_MAX       = 4'd15;
  localparam logic [2:0] ERR_WORD_LEN  = 3'd5;

  // Keyword texts, row = candidate - 1, column = line offset
  localparam logic [7:0] KW_TEXT [4][8] = '{
    '{8'h2B, 8'h43, 8'h53, 8'h43, 8'h4F, 8'h4E, 8'h3A, 8'h00},   // +CSCON:
    '{8'h2B, 8'h43, 8'h45, 8'h52, 8'h45, 8'h47, 8'h3A, 8'h00},   // +CEREG:
    '{8'h2B, 8'h43, 8'h47, 8'h41, 8'h54, 8'h54, 8'h3A, 8'h00},   // +CGATT:
    '{8'h2B, 8'h4E, 8'h53, 8'h4F, 8'h4E, 8'h4D, 8'h49, 8'h3A}    // +NSONMI:
  };

  // "ERROR"
  localparam logic [7:0] ERR_WORD [5] = '{8'h45, 8'h52, 8'h52, 8'h4F, 8'h52};

  // Queue between front and back end
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  localparam int OUT_W = 64;

endpackage
`default_nettype wire

FILE: src/amulp_front.sv
// Front end: takes input beats and classifies them into queue items.
`timescale 1ns / 1ps
`default_nettype none
module amulp_front (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_tvalid,
  output logic              in_tready,
  input  wire  [7:0]        in_tdata,
  input  wire  [1:0]        in_tuser,
  output logic              item_valid,
  output amulp_pkg::item_t  item,
  input  wire               item_ready
);

  logic             valid_r, valid_nxt;
  amulp_pkg::item_t item_r, item_nxt;
  amulp_pkg::kind_t kind;

  always_comb begin
    case (in_tuser)
      amulp_pkg::FUNC_BYTE: begin
        if (in_tdata == amulp_pkg::CH_PLUS)    kind = amulp_pkg::KIND_PLUS;
        else if (in_tdata == amulp_pkg::CH_LF) kind = amulp_pkg::KIND_LF;
        else if (in_tdata == amulp_pkg::CH_CR) kind = amulp_pkg::KIND_CR;
        else                                   kind = amulp_pkg::KIND_BYTE;
      end
      amulp_pkg::FUNC_START:   kind = amulp_pkg::KIND_START;
      amulp_pkg::FUNC_CONSUME: kind = amulp_pkg::KIND_CONSUME;
      default:                 kind = amulp_pkg::KIND_NOP;
    endcase
  end

  assign in_tready  = !valid_r || item_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (in_tvalid && in_tready) begin
      valid_nxt     = 1'b1;
      item_nxt.kind = kind;
      item_nxt.data = in_tdata;
    end else if (item_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule
`default_nettype wire

FILE: src/amulp_queue.sv
// Two-entry queue decoupling the classifier from the parser engine.
`timescale 1ns / 1ps
`default_nettype none
module amulp_queue (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               push_valid,
  output logic              push_ready,
  input  amulp_pkg::item_t  push_item,
  output logic              pop_valid,
  output amulp_pkg::item_t  pop_item,
  input  wire               pop
);

  amulp_pkg::item_t                   mem_r [amulp_pkg::Q_DEPTH];
  logic [amulp_pkg::Q_PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [amulp_pkg::Q_PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [amulp_pkg::Q_CNT_W-1:0]      count_r, count_nxt;
  logic                               do_push, do_pop;

  assign push_ready = (count_r != amulp_pkg::Q_CNT_W'(amulp_pkg::Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop)      count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

FILE: src/amulp_back.sv
// Parser engine: event-line tracking, notice capture and OK/ERROR scan.
`timescale 1ns / 1ps
`default_nettype none
module amulp_back #(
  parameter int NOTICE_MAX = 7
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               q_valid,
  input  amulp_pkg::item_t  q_item,
  output logic              q_pop,
  output logic              out_tvalid,
  input  wire               out_tready,
  output logic [amulp_pkg::OUT_W-1:0] out_tdata
);

  localparam int NOTICE_CAP = (NOTICE_MAX < 7) ? NOTICE_MAX : 7;
  localparam int CAP_W      = NOTICE_CAP * 8;

  logic               out_valid_r, out_valid_nxt;
  logic               in_event_r, in_event_nxt;
  logic [3:0]         line_pos_r, line_pos_nxt;
  amulp_pkg::kw_t     kw_r, kw_nxt;
  logic               flag_r, flag_nxt;
  logic [2:0]         status_r, status_nxt;
  logic [55:0]        notice_r, notice_nxt;
  logic [2:0]         count_r, count_nxt;
  logic [CAP_W-1:0]   capture_r, capture_nxt;
  logic               ok_r, ok_nxt;
  logic [2:0]         err_r, err_nxt;
  amulp_pkg::resp_t   resp_r, resp_nxt;

  logic [7:0]         c;
  logic [3:0]         kw_len;
  logic [3:0]         slot;
  logic [3:0]         n_full;
  logic               advance;
  logic               kw_single;

  assign c       = q_item.data;
  assign q_pop   = q_valid && (!out_valid_r || out_tready);
  assign slot    = line_pos_r - amulp_pkg::NOTICE_KW_LEN;
  assign n_full  = line_pos_r - amulp_pkg::NOTICE_KW_LEN;
  assign kw_len  = (kw_r == amulp_pkg::KW_NSONMI) ? amulp_pkg::NOTICE_KW_LEN
                                                  : amulp_pkg::STATUS_KW_LEN;
  assign kw_single = (kw_r == amulp_pkg::KW_CSCON) || (kw_r == amulp_pkg::KW_CEREG) ||
                     (kw_r == amulp_pkg::KW_CGATT) || (kw_r == amulp_pkg::KW_NSONMI);

  always_comb begin
    out_valid_nxt = out_valid_r;
    in_event_nxt  = in_event_r;
    line_pos_nxt  = line_pos_r;
    kw_nxt        = kw_r;
    flag_nxt      = flag_r;
    status_nxt    = status_r;
    notice_nxt    = notice_r;
    count_nxt     = count_r;
    capture_nxt   = capture_r;
    ok_nxt        = ok_r;
    err_nxt       = err_r;
    resp_nxt      = resp_r;
    advance       = 1'b1;

    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (q_pop) begin
      case (q_item.kind)
        amulp_pkg::KIND_START: begin
          resp_nxt = amulp_pkg::RESP_NONE;
          ok_nxt   = 1'b0;
          err_nxt  = '0;
        end
        amulp_pkg::KIND_CONSUME: begin
          notice_nxt = '0;
          count_nxt  = '0;
        end
        amulp_pkg::KIND_PLUS: begin
          // a plus opens (or restarts) an event line
          in_event_nxt = 1'b1;
          line_pos_nxt = 4'd1;
          kw_nxt       = amulp_pkg::KW_PLUS;
          flag_nxt     = 1'b0;
          capture_nxt  = '0;
        end
        amulp_pkg::KIND_LF, amulp_pkg::KIND_CR, amulp_pkg::KIND_BYTE: begin
          if (in_event_r && q_item.kind == amulp_pkg::KIND_LF) begin
            // line end: commit what the keyword calls for
            if (kw_single && line_pos_r >= kw_len) begin
              if (kw_r == amulp_pkg::KW_NSONMI) begin
                notice_nxt = 56'(capture_r);
                count_nxt  = (n_full > 4'(NOTICE_CAP)) ? 3'(NOTICE_CAP) : n_full[2:0];
              end else begin
                status_nxt[2'(kw_r) - 2'd1] = flag_r;
              end
            end
            in_event_nxt = 1'b0;
            line_pos_nxt = '0;
            kw_nxt       = amulp_pkg::KW_NONE;
            flag_nxt     = 1'b0;
            capture_nxt  = '0;
          end else if (in_event_r) begin
            case (kw_r)
              amulp_pkg::KW_PLUS: begin
                if (c == amulp_pkg::CH_C)      kw_nxt = amulp_pkg::KW_PLUS_C;
                else if (c == amulp_pkg::CH_N) kw_nxt = amulp_pkg::KW_NSONMI;
                else                           kw_nxt = amulp_pkg::KW_NONE;
              end
              amulp_pkg::KW_PLUS_C: begin
                if (c == amulp_pkg::CH_S)      kw_nxt = amulp_pkg::KW_CSCON;
                else if (c == amulp_pkg::CH_E) kw_nxt = amulp_pkg::KW_CEREG;
                else if (c == amulp_pkg::CH_G) kw_nxt = amulp_pkg::KW_CGATT;
                else                           kw_nxt = amulp_pkg::KW_NONE;
              end
              amulp_pkg::KW_CSCON, amulp_pkg::KW_CEREG, amulp_pkg::KW_CGATT,
              amulp_pkg::KW_NSONMI: begin
                if (line_pos_r < kw_len) begin
                  if (c != amulp_pkg::KW_TEXT[2'(kw_r) - 2'd1][line_pos_r[2:0]]) begin
                    kw_nxt = amulp_pkg::KW_NONE;
                  end
                end else if (kw_r != amulp_pkg::KW_NSONMI) begin
                  if (line_pos_r == amulp_pkg::FLAG_POS) begin
                    flag_nxt = (c == amulp_pkg::CH_ONE);
                  end
                end else if (flag_r) begin
                  advance = 1'b0;
                end else if (q_item.kind == amulp_pkg::KIND_CR) begin
                  flag_nxt = 1'b1;
                  advance  = 1'b0;
                end else begin
                  for (int j = 0; j < NOTICE_CAP; j++) begin
                    if (slot == 4'(j)) begin
                      capture_nxt[j*8 +: 8] = c;
                    end
                  end
                end
              end
              default: kw_nxt = amulp_pkg::KW_NONE;
            endcase
            if (advance && line_pos_r < amulp_pkg::POS_MAX) begin
              line_pos_nxt = line_pos_r + 4'd1;
            end
          end else begin
            // command mode: OK / ERROR scan, OK wins
            if (ok_r && c == amulp_pkg::CH_K) begin
              resp_nxt = amulp_pkg::RESP_OK;
            end
            ok_nxt = (c == amulp_pkg::CH_O);
            if (err_r < amulp_pkg::ERR_WORD_LEN && c == amulp_pkg::ERR_WORD[err_r]) begin
              if (err_r + 3'd1 == amulp_pkg::ERR_WORD_LEN) begin
                if (resp_nxt != amulp_pkg::RESP_OK) begin
                  resp_nxt = amulp_pkg::RESP_ERROR;
                end
                err_nxt = '0;
              end else begin
                err_nxt = err_r + 3'd1;
              end
            end else begin
              err_nxt = (c == amulp_pkg::CH_E) ? 3'd1 : 3'd0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      in_event_r  <= 1'b0;
      line_pos_r  <= '0;
      kw_r        <= amulp_pkg::KW_NONE;
      flag_r      <= 1'b0;
      status_r    <= '0;
      notice_r    <= '0;
      count_r     <= '0;
      capture_r   <= '0;
      ok_r        <= 1'b0;
      err_r       <= '0;
      resp_r      <= amulp_pkg::RESP_NONE;
    end else begin
      out_valid_r <= out_valid_nxt;
      in_event_r  <= in_event_nxt;
      line_pos_r  <= line_pos_nxt;
      kw_r        <= kw_nxt;
      flag_r      <= flag_nxt;
      status_r    <= status_nxt;
      notice_r    <= notice_nxt;
      count_r     <= count_nxt;
      capture_r   <= capture_nxt;
      ok_r        <= ok_nxt;
      err_r       <= err_nxt;
      resp_r      <= resp_nxt;
    end
  end

  // state only moves on a pop, so the state registers double as the result
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {resp_r, notice_r, count_r, status_r};

endmodule
`default_nettype wire

FILE: src/at_modem_urc_line_parser_unit.sv
// Top level of the modem event-line parser.
// Usage:
//   Slave channel in_*: one beat per received item. in_tuser carries the
//   function (0 received byte in in_tdata, 1 start of a new command, which
//   clears the response code, 2 consume of the data notice; 3 is ignored).
//   Master channel out_*: exactly one result beat for every accepted beat,
//   carrying the status bits, the captured notice and the response code as
//   they stand after that item.
//   Path from input beat to result beat: classifier register, queue entry,
//   engine/result register.
//   Throughput: one item per cycle; set by the engine update, which only
//   advances when its result register is free or being taken.
//   Reset (rst_n low, synchronous): all line, scan, status and notice state
//   cleared, queue emptied, no result pending.
//   Receiver stall: the result holds; the two-entry queue and the classifier
//   register absorb up to three further beats before in_tready drops.
`timescale 1ns / 1ps
`default_nettype none
module at_modem_urc_line_parser_unit #(
  parameter int NOTICE_MAX = 7
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire  [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  wire         out_tready,
  // [0] conn_up, [1] reg_up, [2] attach_up, [5:3] notice_len,
  // [61:6] notice_text, [63:62] response_code
  output logic [63:0] out_tdata
);

  logic             f_valid, f_ready;
  amulp_pkg::item_t f_item;
  logic             q_valid, q_pop;
  amulp_pkg::item_t q_item;

  amulp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .item_valid (f_valid),
    .item       (f_item),
    .item_ready (f_ready)
  );

  amulp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop        (q_pop)
  );

  amulp_back #(
    .NOTICE_MAX (NOTICE_MAX)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

FILE: src/amulp_checker.sv
// Port-level checks of the parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module amulp_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [63:0] out_tdata
);

  // no result pending straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // response code is none, OK or ERROR
  a_resp_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[63:62] != 2'b11)
    else $error("illegal response code");

  // no notice length means no notice text
  a_notice_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[5:3] == 3'd0) |-> out_tdata[61:6] == 56'd0)
    else $error("notice text without length");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind at_modem_urc_line_parser_unit amulp_checker u_amulp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
